@@ src/lse_pkg.sv @@
// ---------------------------------------------------------------------------
// lse_pkg
// Types, constants and the luma function of the Laplacian sharpness block.
// ---------------------------------------------------------------------------
package lse_pkg;

  localparam int DefMaxWidth = 256;

  localparam int PixelW   = 16;
  localparam int EnergyW  = 40;
  localparam int LumaW    = 8;
  localparam int LineW    = 9;
  localparam int HeightW  = 12;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 12;
  localparam int SqW      = 20;

  localparam logic [LineW-1:0]   LineWidthReset   = 9'd256;
  localparam logic [HeightW-1:0] FrameHeightReset = 12'd192;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegLineWidth   = 1'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'd1;

  localparam logic [6:0] CoefR = 7'd38;
  localparam logic [6:0] CoefG = 7'd75;
  localparam logic [6:0] CoefB = 7'd15;

  // largest square of a Laplacian of 8-bit luma (4*255)^2
  localparam logic [SqW-1:0] SqMax = 20'd1040400;

  typedef enum logic [1:0] {
    StIdle,
    StFetch,
    StEval,
    StAccum
  } lse_state_e;

  // RGB565 to 8-bit luma, channels widened by bit replication
  function automatic logic [LumaW-1:0] luma(input logic [PixelW-1:0] px);
    logic [4:0]  r5;
    logic [5:0]  g6;
    logic [4:0]  b5;
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    logic [14:0] s;
    r5 = px[15:11];
    g6 = px[10:5];
    b5 = px[4:0];
    r8 = {r5, r5[4:2]};
    g8 = {g6, g6[5:4]};
    b8 = {b5, b5[4:2]};
    s  = 15'(r8) * 15'(CoefR) + 15'(g8) * 15'(CoefG) + 15'(b8) * 15'(CoefB);
    return s[14:7];
  endfunction

endpackage

@@ src/lse_if.sv @@
// ---------------------------------------------------------------------------
// lse_if
// Valid/ready channels: pixel items in, energy items out.
// ---------------------------------------------------------------------------
interface lse_pixel_if import lse_pkg::*;;
  logic              valid;
  logic              ready;
  logic [PixelW-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface lse_energy_if import lse_pkg::*;;
  logic               valid;
  logic               ready;
  logic [EnergyW-1:0] energy;

  modport source (output valid, output energy, input ready);
  modport sink   (input valid, input energy, output ready);
endinterface

@@ src/lse_ram.sv @@
// ---------------------------------------------------------------------------
// lse_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lse_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/laplacian_sharpness_energy_top.sv @@
// ---------------------------------------------------------------------------
// laplacian_sharpness_energy_top
// Laplacian energy focus measure over a streamed RGB565 frame.
// ---------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  pixel_i    in   valid/ready    pixel  [15:0] RGB565
//  energy_o   out  valid/ready    energy [39:0] once per frame
//  cfg_*      in   cfg_we_i only  0: line_width, 1: frame_height
//
//  Each pixel item passes through four steps (accept, fetch, evaluate, accumulate) before the next is taken:
//  the two line-store RAMs are read at x and then at x+1 through one port.
//  Reset clears counters, sum and handshakes; the line stores need no clear.
//  A waiting energy item does not block pixel intake; only the last pixel
//  of the next frame waits for the output register to free up.
// ---------------------------------------------------------------------------
module laplacian_sharpness_energy_top import lse_pkg::*; #(
  parameter int MAX_WIDTH = DefMaxWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  lse_pixel_if.sink           pixel_i,
  lse_energy_if.source        energy_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [LineW-1:0] WLim =
      LineW'((MAX_WIDTH < (2**LineW - 1)) ? MAX_WIDTH : (2**LineW - 1));

  lse_state_e state_q, state_d;

  logic [LineW-1:0]   line_width_q;
  logic [HeightW-1:0] frame_height_q;
  logic [LineW-1:0]   col_q;
  logic [HeightW-1:0] row_q;
  logic [EnergyW-1:0] sum_q;
  logic               out_valid_q;
  logic [EnergyW-1:0] out_energy_q;

  logic [LumaW-1:0] cur_q, up_q, mid_q, ws_q;
  logic [LineW-1:0] x_q;
  logic             eval_q, lend_q, fend_q;
  logic [SqW-1:0]   sq_q;

  logic [LineW-1:0]   w_eff, x_c;
  logic [HeightW-1:0] h_eff;
  logic               eval_c, lend_c, fend_c;
  logic               accept, out_free, load_out;
  logic               ram_we;
  logic [AW-1:0]      older_raddr, newer_raddr, waddr;
  logic [LumaW-1:0]   older_rdata, newer_rdata;
  logic signed [10:0] lap;
  logic [9:0]         mag;
  logic [EnergyW-1:0] sum_next;

  // ---- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LineWidthReset;
      frame_height_q <= FrameHeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLineWidth:   line_width_q   <= cfg_wdata_i[LineW-1:0];
        RegFrameHeight: frame_height_q <= cfg_wdata_i[HeightW-1:0];
        default: ;
      endcase
    end
  end

  // ---- position of the incoming pixel
  always_comb begin
    w_eff = line_width_q;
    if (w_eff == '0) begin
      w_eff = LineW'(1);
    end else if (w_eff > WLim) begin
      w_eff = WLim;
    end
    h_eff = (frame_height_q == '0) ? HeightW'(1) : frame_height_q;
    x_c   = (col_q >= w_eff) ? w_eff - LineW'(1) : col_q;
    lend_c = ({1'b0, x_c} + 10'd1) >= {1'b0, w_eff};
    fend_c = lend_c && (({1'b0, row_q} + 13'd1) >= {1'b0, h_eff});
    eval_c = (row_q >= 12'd2) && (x_c != '0) && (({1'b0, x_c} + 10'd2) <= {1'b0, w_eff});
  end

  assign accept   = pixel_i.valid && pixel_i.ready;
  assign out_free = !out_valid_q || energy_o.ready;

  // ---- line stores: older holds row y-2, newer row y-1
  assign waddr       = AW'(x_q);
  assign older_raddr = AW'(x_c);
  assign newer_raddr = (state_q == StFetch) ? AW'(x_q + LineW'(1)) : AW'(x_c);

  lse_ram #(.Width(LumaW), .Depth(MAX_WIDTH)) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (newer_rdata),
    .raddr_i (older_raddr),
    .rdata_o (older_rdata)
  );

  lse_ram #(.Width(LumaW), .Depth(MAX_WIDTH)) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (cur_q),
    .raddr_i (newer_raddr),
    .rdata_o (newer_rdata)
  );

  // ---- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (accept) state_d = StFetch;
      StFetch: state_d = StEval;
      StEval:  state_d = StAccum;
      StAccum: if (!fend_q || out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // ---- outputs of the sequencer
  always_comb begin
    pixel_i.ready = 1'b0;
    ram_we        = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      StIdle:  pixel_i.ready = 1'b1;
      StFetch: ram_we = 1'b1;
      StEval:  ;
      StAccum: load_out = fend_q && out_free;
      default: ;
    endcase
  end

  // ---- Laplacian; newer_rdata holds the right neighbour during StEval
  always_comb begin
    lap = (signed'(11'({mid_q, 2'b00})))
        - signed'(11'(ws_q)) - signed'(11'(newer_rdata))
        - signed'(11'(up_q)) - signed'(11'(cur_q));
    mag = lap[10] ? 10'(-lap) : lap[9:0];
    sum_next = sum_q + (eval_q ? EnergyW'(sq_q) : '0);
  end

  // ---- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      col_q       <= '0;
      row_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (energy_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == StAccum && (!fend_q || out_free)) begin
        sum_q <= fend_q ? '0 : sum_next;
        col_q <= lend_q ? '0 : x_q + LineW'(1);
        if (fend_q) begin
          row_q <= '0;
        end else if (lend_q) begin
          row_q <= row_q + HeightW'(1);
        end
      end
    end
  end

  // ---- datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q  <= luma(pixel_i.pixel);
      x_q    <= x_c;
      eval_q <= eval_c;
      lend_q <= lend_c;
      fend_q <= fend_c;
    end
    if (state_q == StFetch) begin
      up_q  <= older_rdata;
      mid_q <= newer_rdata;
    end
    if (state_q == StEval) begin
      sq_q <= SqW'(mag) * SqW'(mag);
      ws_q <= mid_q;
    end
    if (load_out) begin
      out_energy_q <= sum_next;
    end
  end

  assign energy_o.valid  = out_valid_q;
  assign energy_o.energy = out_energy_q;

  // ---- checks
  a_accept_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == StFetch)
    else $error("accepted pixel did not start a fetch");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StAccum && fend_q))
    else $error("energy item raised outside frame end");

  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> sum_q == '0)
    else $error("sum not cleared after frame end");

  // only interior pixels have all neighbours written
  a_square_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StAccum && eval_q) |-> sq_q <= SqMax)
    else $error("Laplacian square out of range");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Streams RGB565 frames into laplacian_sharpness_energy_top under several
// frame sizes. A behavioral copy of the luma, line-store and Laplacian sum
// predicts each frame's energy, which is compared with the energy items out.
// ---------------------------------------------------------------------------
module tb;
  import lse_pkg::*;

  localparam int ClkPeriod     = 20;
  localparam int WatchdogLimit = 5000;
  localparam int RxHoldCycles  = 400;
  localparam int SettleCycles  = 8;
  localparam int RandomPixels  = 450;
  localparam int MinFrames     = 10;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  lse_pixel_if  pixel_if ();
  lse_energy_if energy_if ();

  laplacian_sharpness_energy_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pixel_i    (pixel_if),
    .energy_o   (energy_if)
  );

  // shadow of the block: registers, line stores, counters, running sum
  logic [LineW-1:0]   cfg_line_width   = LineWidthReset;
  logic [HeightW-1:0] cfg_frame_height = FrameHeightReset;
  logic [LumaW-1:0]   row_above2_luma [DefMaxWidth];
  logic [LumaW-1:0]   row_above1_luma [DefMaxWidth];
  logic [LumaW-1:0]   left_mid_luma    = '0;
  int unsigned        col_pos          = 0;
  logic [HeightW-1:0] row_pos          = '0;
  logic [EnergyW-1:0] energy_running   = '0;

  logic [EnergyW-1:0] pending_energy_q [$];

  int          mismatch_count = 0;
  int          stall_cycles   = 0;
  int          rx_hold_left   = 0;
  bit          tx_gaps_on     = 1'b1;
  bit          rx_gaps_on     = 1'b1;
  logic [PixelW-1:0] last_pixel = '0;

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic int unsigned active_width();
    if (cfg_line_width == 0) return 1;
    if (cfg_line_width > DefMaxWidth) return DefMaxWidth;
    return 32'(cfg_line_width);
  endfunction

  function automatic int unsigned active_height();
    return (cfg_frame_height == 0) ? 1 : 32'(cfg_frame_height);
  endfunction

  function automatic logic [LumaW-1:0] pixel_to_luma(input logic [PixelW-1:0] px);
    int unsigned red, grn, blu;
    red = 32'(px[15:11]);
    grn = 32'(px[10:5]);
    blu = 32'(px[4:0]);
    red = (red << 3) | (red >> 2);
    grn = (grn << 2) | (grn >> 4);
    blu = (blu << 3) | (blu >> 2);
    return LumaW'((red * int'(CoefR) + grn * int'(CoefG) + blu * int'(CoefB)) >> 7);
  endfunction

  // advance the shadow by one accepted pixel; queue the energy on frame end
  task automatic track_pixel_energy(input logic [PixelW-1:0] px);
    int unsigned w, h, x;
    logic [LumaW-1:0] cur, up, mid;
    int lap;
    w   = active_width();
    h   = active_height();
    x   = (col_pos >= w) ? w - 1 : col_pos;
    cur = pixel_to_luma(px);
    up  = row_above2_luma[x];
    mid = row_above1_luma[x];
    // Laplacian centred on the pixel above; the arriving one is its bottom
    if (row_pos >= 2 && x >= 1 && x + 2 <= w) begin
      lap = 4 * int'(mid) - int'(left_mid_luma) - int'(row_above1_luma[x + 1])
            - int'(up) - int'(cur);
      energy_running = energy_running + EnergyW'(lap * lap);
    end
    row_above2_luma[x] = mid;
    row_above1_luma[x] = cur;
    left_mid_luma      = mid;
    if (x + 1 < w) begin
      col_pos = x + 1;
    end else begin
      col_pos = 0;
      if (row_pos + 1 < h) begin
        row_pos = row_pos + 1'b1;
      end else begin
        row_pos = '0;
        pending_energy_q.push_back(energy_running);
        energy_running = '0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [EnergyW-1:0] got,
                                 input logic [EnergyW-1:0] want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_pixel(input logic [PixelW-1:0] px);
    while (tx_gaps_on && $urandom_range(99) < 11) begin
      pixel_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pixel_if.valid <= 1'b1;
    pixel_if.pixel <= px;
    do @(posedge clk_i); while (!pixel_if.ready);
    last_pixel = px;
    track_pixel_energy(px);
  endtask

  // stop offering the last item again while waiting for the results
  task automatic wait_drained();
    if (pixel_if.valid) pixel_if.valid <= 1'b0;
    while (pending_energy_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CfgDataW'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegLineWidth) cfg_line_width = LineW'(value);
    else cfg_frame_height = HeightW'(value);
  endtask

  // registers change only with the block idle at a frame boundary
  task automatic set_frame_size(input int unsigned w, input int unsigned h);
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(RegLineWidth, w);
    write_reg(RegFrameHeight, h);
  endtask

  function automatic logic [PixelW-1:0] rand_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return last_pixel ^ PixelW'($urandom_range(0, 15) << $urandom_range(0, 12));
      default: return PixelW'($urandom);
    endcase
  endfunction

  task automatic send_random_frame();
    int unsigned n;
    n = active_width() * active_height();
    repeat (n) send_pixel(rand_pixel());
  endtask

  // full-scale positive then negative Laplacian on the single interior pixel
  task automatic test_directed_extremes();
    set_frame_size(3, 3);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 16'hFFFF : 16'h0000);
    for (int i = 0; i < 9; i++) send_pixel((i == 4) ? 16'h0000 : 16'hFFFF);
  endtask

  task automatic test_degenerate_sizes();
    set_frame_size(0, 3);   // zero width acts as one
    send_random_frame();
    set_frame_size(1, 5);
    send_random_frame();
    set_frame_size(2, 4);
    send_random_frame();
    set_frame_size(5, 2);
    send_random_frame();
    set_frame_size(4, 0);   // zero height acts as one
    send_random_frame();
    set_frame_size(3, 1);
    send_random_frame();
  endtask

  task automatic test_size_extremes();
    set_frame_size(511, 3); // clamps to the widest line
    send_random_frame();
    set_frame_size(1, 200);
    send_random_frame();
  endtask

  task automatic test_back_to_back();
    set_frame_size(16, 6);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    repeat (4) send_random_frame();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // receiver blocks long enough that the second frame's last item stalls
  task automatic test_output_stall();
    set_frame_size(3, 3);
    tx_gaps_on   = 1'b0;
    rx_hold_left = RxHoldCycles;
    repeat (4) send_random_frame();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned sent, frames, w, h, pick;
    sent   = 0;
    frames = 0;
    while (sent < RandomPixels || frames < MinFrames) begin
      pick = $urandom_range(19);
      if (pick < 2) begin
        w = $urandom_range(0, 2);
        h = $urandom_range(0, 6);
      end else if (pick == 2) begin
        w = $urandom_range(64, 256);
        h = 3;
      end else begin
        w = $urandom_range(3, 12);
        h = $urandom_range(3, 8);
      end
      set_frame_size(w, h);
      // several frames per setting, sometimes with a full drain in between
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(3) == 0) wait_drained();
        send_random_frame();
        sent += active_width() * active_height();
        frames++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < DefMaxWidth; i++) begin
      row_above2_luma[i] = '0;
      row_above1_luma[i] = '0;
    end
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = RegLineWidth;
    cfg_wdata_i     = '0;
    pixel_if.valid  = 1'b0;
    pixel_if.pixel  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_degenerate_sizes();
    test_size_extremes();
    test_back_to_back();
    test_output_stall();
    test_random_frames();

    @(posedge clk_i);
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (pending_energy_q.size() != 0) begin
      $display("ERROR %0t: %0d energy items never arrived", $time, pending_energy_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial energy_if.ready = 1'b0;

  always @(posedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      energy_if.ready <= 1'b0;
    end else if (rx_gaps_on) begin
      energy_if.ready <= ($urandom_range(99) >= 11);
    end else begin
      energy_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    logic [EnergyW-1:0] want;
    if (rst_ni && energy_if.valid && energy_if.ready) begin
      if (pending_energy_q.size() == 0) begin
        report_mismatch("energy item with none pending:", energy_if.energy, '0);
      end else begin
        want = pending_energy_q.pop_front();
        if (energy_if.energy !== want) report_mismatch("energy", energy_if.energy, want);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((pixel_if.valid && pixel_if.ready) || (energy_if.valid && energy_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WatchdogLimit) begin
      $display("ERROR %0t: no handshake for %0d cycles", $time, stall_cycles);
      $display("tb: failure");
      $finish;
    end
  end

endmodule
